// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property on a clock, disabled while reset is asserted.
`define ASSERT_PROP(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// A stalled request must keep its payload until it is taken.
`define ASSERT_STABLE(name, clk, rst_n, vld, rdy, sig) \
  `ASSERT_PROP(name, clk, rst_n, ((vld) && !(rdy)) |=> ((vld) && $stable(sig)))

`endif

// ===== hw/rtl/tart_pkg.sv =====
package tart_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 16;

  localparam int unsigned IDX_W      = 4;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BUDGET_W   = 31;
  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 136;

  localparam logic [WORD_W-1:0] WARMUP_LOOPS        = 32'd100;
  localparam logic [WORD_W-1:0] MARGIN_SWITCH_LOOPS = 32'd450;
  localparam logic [WORD_W-1:0] STABLE_LOOPS        = 32'd500;

  typedef enum logic {
    OP_CHECK  = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] last_end_time;
    logic [WORD_W-1:0] runtime_sum;
    logic [WORD_W-1:0] runtime_average;
    logic [WORD_W-1:0] runtime_maximum;
    logic [WORD_W-1:0] runtime_peak;
    logic [WORD_W-1:0] worst_est;
  } slot_t;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  task_index;
    logic [MASK_W-1:0] firmware_state_mask;
    logic [MASK_W-1:0] task_class_mask;
    logic [WORD_W-1:0] period;
    logic              realtime_req;
    logic [WORD_W-1:0] loop_start_cycles;
    logic [WORD_W-1:0] now_cycles;
    logic [WORD_W-1:0] run_start_cycles;
    logic [WORD_W-1:0] loop_count;
    logic              skip_stats;
    logic              in_range;
  } item_t;

  typedef struct packed {
    logic stage_a_en;
    logic stage_b_en;
  } upd_ctrl_t;

endpackage

// ===== hw/rtl/tart_table.sv =====
module tart_table import tart_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int unsigned SLOT_AW    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [SLOT_AW-1:0] rd_addr_i,
  input  logic               wr_en_i,
  input  logic [SLOT_AW-1:0] wr_addr_i,
  input  slot_t              wr_data_i,
  output slot_t              rd_data_o
);

  slot_t                  mem [TASK_SLOTS];
  slot_t                  rd_data_q;
  logic [TASK_SLOTS-1:0]  valid_q;
  logic                   rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/tart_update.sv =====
module tart_update import tart_pkg::*; (
  input  logic                clk_i,
  input  upd_ctrl_t           ctrl_i,
  input  item_t               item_i,
  input  slot_t               slot_i,
  input  logic [BUDGET_W-1:0] budget_i,
  output slot_t               slot_o,
  output logic                run_now_o
);

  // Stage A: admission test, running sum, maximum, peak candidates.
  logic [WORD_W-1:0] taken;
  logic [WORD_W-1:0] since_end;
  logic [WORD_W-1:0] budget_left;
  logic              mask_ok;
  logic              period_ok;
  logic              over_budget;
  logic [WORD_W+1:0] shrink_full;
  logic [WORD_W:0]   sum_full;
  logic [WORD_W-1:0] sum_new;
  logic [WORD_W+2:0] up7_full;
  logic [WORD_W+4:0] up31_full;

  slot_t             a_slot_q;
  logic              a_run_q;
  logic [WORD_W-1:0] a_worst_q;
  logic [WORD_W-1:0] a_taken_q;
  logic [WORD_W-1:0] a_sum_q;
  logic [WORD_W-1:0] a_avg_q;
  logic [WORD_W-1:0] a_max_q;
  logic [WORD_W-1:0] a_up7_q;
  logic [WORD_W-1:0] a_up31_q;

  assign taken       = item_i.now_cycles - item_i.run_start_cycles;
  assign mask_ok     = |(item_i.firmware_state_mask & item_i.task_class_mask);
  assign since_end   = item_i.loop_start_cycles - slot_i.last_end_time;
  assign period_ok   = (item_i.period == '0) || (since_end >= item_i.period);
  assign budget_left = {1'b0, budget_i} - (item_i.now_cycles - item_i.loop_start_cycles);
  // Time left is signed: a negative value counts as over budget.
  assign over_budget = budget_left[WORD_W-1] || (slot_i.worst_est > budget_left);
  assign shrink_full = {2'b00, slot_i.worst_est} + {1'b0, slot_i.worst_est, 1'b0};

  // Stored average never exceeds stored sum, so no borrow here.
  assign sum_full = {1'b0, slot_i.runtime_sum} - {1'b0, slot_i.runtime_average}
                  + {1'b0, taken};
  assign sum_new  = sum_full[WORD_W] ? '1 : sum_full[WORD_W-1:0];

  assign up7_full  = (WORD_W+3)'(slot_i.runtime_peak) * (WORD_W+3)'(7)
                   + (WORD_W+3)'(taken);
  assign up31_full = (WORD_W+5)'(slot_i.runtime_peak) * (WORD_W+5)'(31)
                   + (WORD_W+5)'(taken);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.stage_a_en) begin
      a_slot_q  <= slot_i;
      a_run_q   <= mask_ok && period_ok && (!over_budget || item_i.realtime_req);
      a_worst_q <= (mask_ok && period_ok && over_budget && !item_i.realtime_req)
                   ? shrink_full[WORD_W+1:2] : slot_i.worst_est;
      a_taken_q <= taken;
      a_sum_q   <= sum_new;
      a_avg_q   <= {5'b0, sum_new[WORD_W-1:5]};
      a_max_q   <= (taken > slot_i.runtime_maximum) ? taken : slot_i.runtime_maximum;
      a_up7_q   <= up7_full[WORD_W+2:3];
      a_up31_q  <= up31_full[WORD_W+4:5];
    end
  end

  // Stage B: pick the peak update, decay it, form the average margin.
  logic [WORD_W-1:0] peak_sel;
  logic [WORD_W+8:0] decay_full;
  logic [WORD_W-1:0] peak_new;
  logic [WORD_W+2:0] marg_full;
  logic [WORD_W-1:0] b_peak_q;
  logic [WORD_W-1:0] b_marg_q;

  always_comb begin
    peak_sel = a_slot_q.runtime_peak;
    if (a_taken_q > a_avg_q) begin
      if (a_slot_q.runtime_peak == '0) begin
        peak_sel = a_taken_q;
      end else if (a_taken_q > a_slot_q.runtime_peak) begin
        peak_sel = a_up7_q;
      end else begin
        peak_sel = a_up31_q;
      end
    end
  end

  assign decay_full = (WORD_W+9)'(peak_sel) * (WORD_W+9)'(511);
  assign peak_new   = (peak_sel > a_avg_q) ? decay_full[WORD_W+8:9] : peak_sel;
  assign marg_full  = (WORD_W+3)'(a_avg_q)
                    * ((item_i.loop_count < MARGIN_SWITCH_LOOPS) ? (WORD_W+3)'(6)
                                                                 : (WORD_W+3)'(5));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.stage_b_en) begin
      b_peak_q <= peak_new;
      b_marg_q <= marg_full[WORD_W+2] ? '1 : marg_full[WORD_W+1:2];
    end
  end

  // Write-back stage: worst estimate and the record to store.
  logic [WORD_W+3:0] peak9_full;
  logic [WORD_W-1:0] peak9;
  logic [WORD_W-1:0] worst_report;
  logic              stats_en;

  assign peak9_full = (WORD_W+4)'(b_peak_q) * (WORD_W+4)'(9);
  assign peak9      = peak9_full[WORD_W+3] ? '1 : peak9_full[WORD_W+2:3];
  assign stats_en   = (item_i.loop_count >= WARMUP_LOOPS) && !item_i.skip_stats;

  always_comb begin
    if ((b_peak_q != '0) && (item_i.loop_count > STABLE_LOOPS)) begin
      worst_report = peak9;
    end else if (a_slot_q.worst_est < b_marg_q) begin
      worst_report = b_marg_q;
    end else begin
      worst_report = a_slot_q.worst_est;
    end
  end

  always_comb begin
    slot_o    = a_slot_q;
    run_now_o = 1'b0;
    if (!item_i.in_range) begin
      slot_o = '0;
    end else begin
      unique case (item_i.op)
        OP_CHECK: begin
          slot_o.worst_est = a_worst_q;
          run_now_o        = a_run_q;
        end
        OP_REPORT: begin
          slot_o.last_end_time = item_i.now_cycles;
          if (stats_en) begin
            slot_o.runtime_sum     = a_sum_q;
            slot_o.runtime_average = a_avg_q;
            slot_o.runtime_maximum = a_max_q;
            slot_o.runtime_peak    = b_peak_q;
            slot_o.worst_est       = worst_report;
          end
        end
        default: begin
          slot_o = '0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/task_admission_runtime_tracker_core.sv =====
// Flow: an accepted request passes through the table read, stage A, stage B and the
//   write-back, which loads the output register; these run in series for the same
//   table entry, one request at a time, so no new request is taken before the last
//   is written back. A result still held in the output register stalls the write-back.
// Reset: control and the loop budget clear; per-entry valid bits clear at once,
//   so every table entry reads as zero until written. No clearing pass.
module task_admission_runtime_tracker_core import tart_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] task_index, [11:4] firmware_state_mask, [19:12] task_class_mask,
  // [51:20] period, [52] realtime_req, [84:53] loop_start_cycles,
  // [116:85] now_cycles, [148:117] run_start_cycles, [180:149] loop_count,
  // [181] skip_stats, [183:182] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic [0:0]            s_axis_tuser,
  // Result stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] run_now, [32:1] worst_estimate, [64:33] average_runtime,
  // [96:65] max_runtime, [128:97] peak_estimate, [135:129] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Loop budget register write.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [BUDGET_W-1:0]   cfg_data_i
);

  localparam int unsigned SLOT_AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // One-hot sequencer: read issued on accept, then two update stages, then write-back.
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_STAGE_A = 4'b0010,
    S_STAGE_B = 4'b0100,
    S_WRITE   = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  item_t                 item_q, item_d;
  logic [BUDGET_W-1:0]   budget_q;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  accept;
  logic                  out_free;
  logic                  commit;
  logic [SLOT_AW+IDX_W-1:0] in_idx_ext;
  logic [SLOT_AW+IDX_W-1:0] q_idx_ext;
  slot_t                 rd_slot;
  slot_t                 new_slot;
  logic                  run_now;
  upd_ctrl_t             ctrl;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign commit        = (state_q == S_WRITE) && out_free;
  assign cfg_ready_o   = 1'b1;

  // Unpack the request fields.
  always_comb begin
    item_d.op                  = op_e'(s_axis_tuser[0]);
    item_d.task_index          = s_axis_tdata[3:0];
    item_d.firmware_state_mask = s_axis_tdata[11:4];
    item_d.task_class_mask     = s_axis_tdata[19:12];
    item_d.period              = s_axis_tdata[51:20];
    item_d.realtime_req        = s_axis_tdata[52];
    item_d.loop_start_cycles   = s_axis_tdata[84:53];
    item_d.now_cycles          = s_axis_tdata[116:85];
    item_d.run_start_cycles    = s_axis_tdata[148:117];
    item_d.loop_count          = s_axis_tdata[180:149];
    item_d.skip_stats          = s_axis_tdata[181];
    item_d.in_range            = ({28'b0, s_axis_tdata[3:0]} < 32'(TASK_SLOTS));
  end

  assign in_idx_ext = (SLOT_AW+IDX_W)'(item_d.task_index);
  assign q_idx_ext  = (SLOT_AW+IDX_W)'(item_q.task_index);

  // Hold the request for the whole read-modify-write.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      budget_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl.stage_a_en = 1'b0;
    ctrl.stage_b_en = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_STAGE_A;
        end
      end
      S_STAGE_A: begin
        ctrl.stage_a_en = 1'b1;
        state_d         = S_STAGE_B;
      end
      S_STAGE_B: begin
        ctrl.stage_b_en = 1'b1;
        state_d         = S_WRITE;
      end
      S_WRITE: begin
        // Wait here while the previous result still sits in the output register.
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table: read on accept, write back the updated entry on commit. The next
  // read cannot start before the write lands, so no forwarding is needed.
  tart_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .SLOT_AW    (SLOT_AW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_idx_ext[SLOT_AW-1:0]),
    .wr_en_i   (commit && item_q.in_range),
    .wr_addr_i (q_idx_ext[SLOT_AW-1:0]),
    .wr_data_i (new_slot),
    .rd_data_o (rd_slot)
  );

  tart_update u_update (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .item_i    (item_q),
    .slot_i    (rd_slot),
    .budget_i  (budget_q),
    .slot_o    (new_slot),
    .run_now_o (run_now)
  );

  // Output register: load on commit, drop when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q <= {7'b0, new_slot.runtime_peak, new_slot.runtime_maximum,
                     new_slot.runtime_average, new_slot.worst_est, run_now};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/tart_checker.sv =====
`include "assert_macros.svh"

module tart_checker import tart_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic in_take;

  assign in_take = s_axis_tvalid && s_axis_tready;

  `ASSERT_STABLE(result_held, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata)
  `ASSERT_PROP(single_request_a, clk_i, rst_ni, in_take |=> !s_axis_tready)
  `ASSERT_PROP(single_request_b, clk_i, rst_ni, in_take |=> ##2 !s_axis_tready)
  `ASSERT_PROP(result_from_request, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_take, 4))

endmodule

bind task_admission_runtime_tracker_core tart_checker u_tart_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
